// ----- rtl/core/twc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package twc_pkg;
    localparam int WayCount     = 2;
    localparam int SetIndexBits = 10;
    localparam int EntryWidth   = 64;
    localparam int IndexWidth   = 32;
    localparam int TagWidth     = IndexWidth - SetIndexBits;
    localparam int CountWidth   = 16;
    localparam int SetCount     = 1 << SetIndexBits;
    localparam int WayBits      = (WayCount > 1) ? $clog2(WayCount) : 1;
    localparam logic [CountWidth-1:0] CountMax = '1;

    typedef struct packed {
        logic [IndexWidth-1:0] index;
        logic [63:0]           fill_data;
    } req_t;

    typedef struct packed {
        logic [63:0] data;
        logic        hit;
        logic        way_used;
    } rsp_t;

    // Request after the front end has split it into set and tag.
    typedef struct packed {
        logic [SetIndexBits-1:0] set_idx;
        logic [TagWidth-1:0]     tag;
        logic [EntryWidth-1:0]   word;
    } cmd_t;
endpackage
`default_nettype wire

// ----- rtl/core/two_way_cache_counter_lru.sv -----
// Two-way read cache with counter-based replacement.
// Input channel s_*: a request carries an index and the backing word for
// that index. Output channel m_*: one result per request with the word,
// a hit flag and the way that hit or was filled.
// A front stage splits each request into set and tag and holds up to two
// in a queue; the back end reads the whole set from one memory per way,
// updates counters, tags and data, and writes the set back.
// From acceptance, the set is read into a register, then the result is
// registered and m_valid rises. The back end takes no new request until
// the result is taken, as it steps through the read and write-back of
// the set memory and the result register. A clear pass over all 1024
// sets follows reset; requests are queued (two at most) but not served during it.
// When the receiver holds m_ready low, the result stays in place and the
// queue fills, after which s_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module two_way_cache_counter_lru (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire twc_pkg::req_t s_payload,
    output logic               m_valid,
    input  wire logic          m_ready,
    output twc_pkg::rsp_t      m_payload
);
    import twc_pkg::*;

    logic q_valid, q_ready;
    cmd_t q_cmd;

    // Front end and queue.
    twc_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_payload,
        .q_valid, .q_ready, .q_cmd
    );

    // Lookup and update engine.
    twc_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .m_valid, .m_ready, .m_payload
    );
endmodule
`default_nettype wire

// ----- rtl/core/twc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module twc_front (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire twc_pkg::req_t s_payload,
    output logic              q_valid,
    input  wire logic         q_ready,
    output twc_pkg::cmd_t     q_cmd
);
    import twc_pkg::*;

    // Two-entry queue of classified requests.
    cmd_t       buf_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;
    cmd_t       cmd_in;
    logic       push, pop;

    assign cmd_in.set_idx = s_payload.index[SetIndexBits-1:0];
    assign cmd_in.tag     = s_payload.index[IndexWidth-1:SetIndexBits];
    assign cmd_in.word    = s_payload.fill_data[EntryWidth-1:0];

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = buf_reg[rd_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        else if (pop && !push) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (push) buf_reg[wr_reg] <= cmd_in;
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (pop)  rd_reg <= ~rd_reg;
            if (push) wr_reg <= ~wr_reg;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/twc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module twc_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire twc_pkg::cmd_t q_cmd,
    output logic               m_valid,
    input  wire logic          m_ready,
    output twc_pkg::rsp_t      m_payload
);
    import twc_pkg::*;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_DONE} state_t;

    typedef struct packed {
        logic                  valid;
        logic [CountWidth-1:0] cnt;
        logic [TagWidth-1:0]   tag;
        logic [EntryWidth-1:0] data;
    } line_t;

    // One memory per way; the whole set is read and written at one address.
    line_t mem [WayCount][SetCount];
    line_t rd_reg [WayCount];
    line_t wr_line [WayCount];
    logic  [WayCount-1:0] wr_en;

    state_t                  state_reg;
    logic [SetIndexBits:0]   clr_reg;
    cmd_t                    cmd_reg;
    rsp_t                    rsp_reg;
    logic [SetIndexBits-1:0] wr_addr;

    // Lookup and replacement on the registered set.
    logic [WayCount-1:0]   match;
    logic                  hit;
    logic [WayBits-1:0]    hway, vway, way;
    logic                  found_inv;
    logic [CountWidth-1:0] least, top;
    logic [CountWidth-1:0] new_cnt [WayCount];

    always_comb begin
        hit = 1'b0; hway = '0; found_inv = 1'b0; vway = '0; least = CountMax;
        for (int w = WayCount - 1; w >= 0; w--) begin
            match[w] = rd_reg[w].valid && rd_reg[w].tag == cmd_reg.tag;
            if (match[w]) begin hit = 1'b1; hway = WayBits'(w); end
        end
        for (int w = 0; w < WayCount; w++) begin
            if (!found_inv) begin
                if (!rd_reg[w].valid) begin
                    found_inv = 1'b1; vway = WayBits'(w);
                end else if (rd_reg[w].cnt < least) begin
                    least = rd_reg[w].cnt; vway = WayBits'(w);
                end
            end
        end
        way = hit ? hway : vway;
        top = '0;
        for (int w = 0; w < WayCount; w++)
            if (WayBits'(w) != way && rd_reg[w].valid && rd_reg[w].cnt > top)
                top = rd_reg[w].cnt;
        for (int w = 0; w < WayCount; w++) begin
            wr_line[w] = rd_reg[w];
            new_cnt[w] = rd_reg[w].cnt;
        end
        if (hit && rd_reg[hway].cnt != CountMax) begin
            new_cnt[hway] = rd_reg[hway].cnt + 1'b1;
        end else begin
            for (int w = 0; w < WayCount; w++)
                if (WayBits'(w) != way && rd_reg[w].valid)
                    new_cnt[w] = rd_reg[w].cnt >> 2;
            new_cnt[way] = (top >> 2) + 1'b1;
        end
        for (int w = 0; w < WayCount; w++) wr_line[w].cnt = new_cnt[w];
        if (!hit) begin
            wr_line[way].valid = 1'b1;
            wr_line[way].tag   = cmd_reg.tag;
            wr_line[way].data  = cmd_reg.word;
        end
        wr_en = '0;
        if (state_reg == ST_CLEAR) begin
            wr_en = '1;
            for (int w = 0; w < WayCount; w++) wr_line[w] = '0;
        end else if (state_reg == ST_READ) begin
            wr_en = '1;
        end
        wr_addr = (state_reg == ST_CLEAR) ? clr_reg[SetIndexBits-1:0]
                                          : cmd_reg.set_idx;
    end

    // Set memories: read address comes from the queue head.
    always_ff @(posedge aclk) begin
        for (int w = 0; w < WayCount; w++) begin
            if (wr_en[w]) mem[w][wr_addr] <= wr_line[w];
            rd_reg[w] <= mem[w][q_cmd.set_idx];
        end
    end

    assign q_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_DONE);
    assign m_payload = rsp_reg;

    // Sequencer: clear pass, read set, update set, present result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (SetIndexBits+1)'(SetCount - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: if (q_valid) begin
                    cmd_reg   <= q_cmd;
                    state_reg <= ST_READ;
                end
                ST_READ: begin
                    rsp_reg.data     <= 64'(hit ? rd_reg[hway].data : cmd_reg.word);
                    rsp_reg.hit      <= hit;
                    rsp_reg.way_used <= way[0];
                    state_reg        <= ST_DONE;
                end
                ST_DONE: if (m_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/twc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module twc_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire twc_pkg::rsp_t m_payload
);
    // A held result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // No result can be reported right after reset.
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result out of reset");

    // Results are never back to back: m_valid drops after each accepted result.
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid)
        else $error("back-to-back results");

    // Ready does not drop without an accepted request.
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && !s_valid |=> s_ready)
        else $error("queue lost space");
endmodule

bind two_way_cache_counter_lru twc_checker u_twc_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_payload
);
`default_nettype wire

// ----- sim/two_way_cache_counter_lru_tb.sv -----
`timescale 1ns / 1ps
module two_way_cache_counter_lru_tb;
    import twc_pkg::*;

    localparam int CycleLimit = 400000;

    // Mirror of the cache contents, used to work out each expected response.
    class cache_scoreboard;
        logic [TagWidth-1:0]   tag_mem [WayCount*SetCount];
        bit                    valid_mem [WayCount*SetCount];
        logic [CountWidth-1:0] count_mem [WayCount*SetCount];
        logic [EntryWidth-1:0] data_mem [WayCount*SetCount];
        rsp_t                  pending_rsp [$];
        int                    errors;
        int                    hits;
        int                    misses;
        int                    saturations;

        function new();
            for (int k = 0; k < WayCount*SetCount; k++) begin
                valid_mem[k] = 0;
                count_mem[k] = '0;
            end
            errors = 0;
            hits = 0;
            misses = 0;
            saturations = 0;
        endfunction

        // Other valid ways shift down; the recent way takes the old top >> 2, plus one.
        function void rescale(int base, int recent);
            logic [CountWidth-1:0] top;
            top = '0;
            for (int w = 0; w < WayCount; w++) begin
                if (w != recent && valid_mem[base+w]) begin
                    if (count_mem[base+w] > top) top = count_mem[base+w];
                    count_mem[base+w] = count_mem[base+w] >> 2;
                end
            end
            count_mem[base+recent] = (top >> 2) + 1'b1;
        endfunction

        function void note_request(req_t rq);
            int set_no;
            int base;
            int victim;
            logic [CountWidth-1:0] least;
            logic [TagWidth-1:0] tg;
            rsp_t rs;
            set_no = int'(rq.index[SetIndexBits-1:0]);
            tg = rq.index[IndexWidth-1:SetIndexBits];
            base = set_no * WayCount;
            for (int w = 0; w < WayCount; w++) begin
                if (valid_mem[base+w] && tag_mem[base+w] == tg) begin
                    if (count_mem[base+w] == CountMax) begin
                        rescale(base, w);
                        saturations++;
                    end else begin
                        count_mem[base+w] = count_mem[base+w] + 1'b1;
                    end
                    rs.data = data_mem[base+w];
                    rs.hit = 1'b1;
                    rs.way_used = w[0];
                    pending_rsp.push_back(rs);
                    hits++;
                    return;
                end
            end
            // Victim: first invalid way, else lowest way with the smallest count.
            victim = -1;
            least = CountMax;
            for (int w = 0; w < WayCount; w++) begin
                if (victim < 0 && !valid_mem[base+w]) victim = w;
            end
            if (victim < 0) begin
                victim = 0;
                for (int w = 0; w < WayCount; w++) begin
                    if (count_mem[base+w] < least) begin
                        least = count_mem[base+w];
                        victim = w;
                    end
                end
            end
            data_mem[base+victim] = rq.fill_data[EntryWidth-1:0];
            tag_mem[base+victim] = tg;
            valid_mem[base+victim] = 1;
            rescale(base, victim);
            rs.data = rq.fill_data[EntryWidth-1:0];
            rs.hit = 1'b0;
            rs.way_used = victim[0];
            pending_rsp.push_back(rs);
            misses++;
        endfunction

        task report_error(string what, rsp_t got, rsp_t want);
            errors++;
            $display("ERROR: %s: got data=%h hit=%b way=%b, want data=%h hit=%b way=%b",
                     what, got.data, got.hit, got.way_used,
                     want.data, want.hit, want.way_used);
        endtask

        task check_response(rsp_t got);
            rsp_t want;
            if (pending_rsp.size() == 0) begin
                report_error("response with no request outstanding", got, got);
                return;
            end
            want = pending_rsp.pop_front();
            if (got.data !== want.data) report_error("data mismatch", got, want);
            if (got.hit !== want.hit) report_error("hit flag mismatch", got, want);
            if (got.way_used !== want.way_used) report_error("way mismatch", got, want);
        endtask
    endclass

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    req_t  s_payload;
    logic  m_valid;
    logic  m_ready;
    rsp_t  m_payload;

    cache_scoreboard sb;
    int cycle_count;
    bit calm_phase;
    bit hold_phase;
    bit stim_done;
    logic [TagWidth-1:0] hot_tags [4];

    two_way_cache_counter_lru u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Hang guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Score responses and drive m_ready: random stalls, calm stretches and one long hold.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_response(m_payload);
            if (hold_phase) m_ready <= 1'b0;
            else if (calm_phase) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(99) >= 37);
        end
    end

    // Present one request and hold it until accepted; idle gaps drop valid first.
    task automatic send_request(logic [31:0] idx, logic [63:0] word);
        if (!calm_phase && $urandom_range(99) < 37) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < 37) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= '{index: idx, fill_data: word};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(s_payload);
    endtask

    function automatic logic [31:0] make_index(logic [TagWidth-1:0] tg, int set_no);
        return {tg, set_no[SetIndexBits-1:0]};
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        logic [31:0] idx;
        int pick;
        sb = new();
        cycle_count = 0;
        calm_phase = 0;
        hold_phase = 0;
        stim_done = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_payload = '0;
        m_ready = 1'b0;
        for (int i = 0; i < 4; i++) hot_tags[i] = TagWidth'($urandom());
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extreme indexes and words, a hit, both ways, an eviction.
        send_request(32'h0000_0000, 64'h0);
        send_request(32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(32'hFFFF_FFFF, 64'h0);
        send_request(32'hFFFF_FC00, 64'hA5A5_5A5A_0F0F_F0F0);
        send_request(32'h0000_03FF, 64'h1234_5678_9ABC_DEF0);
        send_request(32'hFFFF_FC00, 64'h0);
        send_request(32'h0000_0400, 64'h5555_AAAA_5555_AAAA);
        send_request(32'h0000_0800, 64'hAAAA_5555_AAAA_5555);
        send_request(32'h0000_0400, 64'h0);
        send_request(32'h0000_0000, 64'h1);
        send_request(32'h0000_0800, 64'h8000_0000_0000_0000);

        // Long receiver hold while requests keep coming.
        fork
            begin
                hold_phase = 1;
                repeat (300) @(posedge aclk);
                hold_phase = 0;
            end
            for (int i = 0; i < 30; i++) send_request($urandom(), rand_word());
        join

        // Random: mostly reuse of a few tags on a few sets, some noise.
        for (int n = 0; n < 1408; n++) begin
            if (n == 500) calm_phase = 1;
            if (n == 700) calm_phase = 0;
            pick = $urandom_range(99);
            if (pick < 75)
                idx = make_index(hot_tags[$urandom_range(3)], $urandom_range(7));
            else
                idx = $urandom();
            send_request(idx, rand_word());
        end
        s_valid <= 1'b0;
        stim_done = 1;

        while (sb.pending_rsp.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Covered %0d hits, %0d misses and %0d counter saturations.",
                 sb.hits, sb.misses, sb.saturations);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/twc_pkg.sv
rtl/core/twc_front.sv
rtl/core/twc_back.sv
rtl/core/two_way_cache_counter_lru.sv
rtl/core/twc_checker.sv
sim/two_way_cache_counter_lru_tb.sv
